/* sv/sm83alu_pkg.sv */
package sm83alu_pkg;

    // Operation codes carried in the cmd field of a request.
    typedef enum logic [3:0] {
        CMD_AND    = 4'd0,
        CMD_XOR    = 4'd1,
        CMD_OR     = 4'd2,
        CMD_CP     = 4'd3,
        CMD_DAA    = 4'd4,
        CMD_INC8   = 4'd5,
        CMD_DEC8   = 4'd6,
        CMD_INC16  = 4'd7,
        CMD_DEC16  = 4'd8,
        CMD_SUB    = 4'd9,
        CMD_SBC    = 4'd10,
        CMD_ADC    = 4'd11,
        CMD_ADD8   = 4'd12,
        CMD_ADD16  = 4'd13,
        CMD_ADD_SP = 4'd14
    } cmd_t;

    // Flag bit positions in flags_in and flags_out.
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    localparam int unsigned CMD_W   = 4;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned FLAGS_W = 4;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 24;

    typedef struct packed {
        logic [FLAGS_W-1:0] flags_in;
        logic [WORD_W-1:0]  operand_b;
        logic [WORD_W-1:0]  operand_a;
        logic [CMD_W-1:0]   cmd;
    } alu_req_t;

    typedef struct packed {
        logic [FLAGS_W-1:0] flags_out;
        logic [WORD_W-1:0]  result;
    } alu_rsp_t;

endpackage

/* sv/sm83alu_exec.sv */
module sm83alu_exec
(
    input  sm83alu_pkg::alu_req_t req,
    output sm83alu_pkg::alu_rsp_t rsp
);

    always_comb
    begin
        logic [7:0]  a;
        logic [7:0]  b;
        logic        cin;
        logic        cin_eff;
        logic [8:0]  sum9;
        logic [4:0]  hsum5;
        logic [8:0]  diff9;
        logic [4:0]  hdiff5;
        logic [7:0]  res8;
        logic [7:0]  adj;
        logic        nf;
        logic        setc;
        logic [16:0] sum17;
        logic [12:0] sum13;
        logic [15:0] ext;
        logic        zf;

        a       = req.operand_a[7:0];
        b       = req.operand_b[7:0];
        cin     = req.flags_in[sm83alu_pkg::FLAG_C];
        nf      = req.flags_in[sm83alu_pkg::FLAG_N];
        // Only the carry-using operations feed the incoming carry in.
        cin_eff = ((req.cmd == sm83alu_pkg::CMD_ADC) || (req.cmd == sm83alu_pkg::CMD_SBC))
                  ? cin : 1'b0;

        sum9   = {1'b0, a} + {1'b0, b} + {8'd0, cin_eff};
        hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin_eff};
        // A borrow shows up as the top bit of the widened difference.
        diff9  = {1'b0, a} - {1'b0, b} - {8'd0, cin_eff};
        hdiff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin_eff};

        adj  = 8'h00;
        setc = 1'b0;
        if (req.flags_in[sm83alu_pkg::FLAG_H] || (!nf && (a[3:0] > 4'd9)))
        begin
            adj = 8'h06;
        end
        if (cin || (!nf && (a > 8'h99)))
        begin
            adj  = adj | 8'h60;
            setc = 1'b1;
        end

        sum17 = {1'b0, req.operand_a} + {1'b0, req.operand_b};
        sum13 = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
        ext   = {{8{b[7]}}, b};

        res8 = 8'h00;
        zf   = 1'b0;
        rsp.result    = req.operand_a;
        rsp.flags_out = req.flags_in;

        case (req.cmd)
            sm83alu_pkg::CMD_AND:
            begin
                res8 = a & b;
                zf   = (res8 == 8'h00);
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {zf, 1'b0, 1'b1, 1'b0};
            end
            sm83alu_pkg::CMD_XOR:
            begin
                res8 = a ^ b;
                zf   = (res8 == 8'h00);
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {zf, 1'b0, 1'b0, 1'b0};
            end
            sm83alu_pkg::CMD_OR:
            begin
                res8 = a | b;
                zf   = (res8 == 8'h00);
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {zf, 1'b0, 1'b0, 1'b0};
            end
            sm83alu_pkg::CMD_CP:
            begin
                rsp.result    = {8'h00, a};
                rsp.flags_out = {(diff9[7:0] == 8'h00), 1'b1, hdiff5[4], diff9[8]};
            end
            sm83alu_pkg::CMD_DAA:
            begin
                res8 = nf ? (a - adj) : (a + adj);
                zf   = (res8 == 8'h00);
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {zf, nf, 1'b0, setc};
            end
            sm83alu_pkg::CMD_INC8:
            begin
                res8 = a + 8'd1;
                zf   = (res8 == 8'h00);
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {zf, 1'b0, (res8[3:0] == 4'h0), cin};
            end
            sm83alu_pkg::CMD_DEC8:
            begin
                res8 = a - 8'd1;
                zf   = (res8 == 8'h00);
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {zf, 1'b1, (res8[3:0] == 4'hF), cin};
            end
            sm83alu_pkg::CMD_INC16:
            begin
                rsp.result = req.operand_a + 16'd1;
            end
            sm83alu_pkg::CMD_DEC16:
            begin
                rsp.result = req.operand_a - 16'd1;
            end
            sm83alu_pkg::CMD_SUB, sm83alu_pkg::CMD_SBC:
            begin
                zf = (diff9[7:0] == 8'h00);
                rsp.result    = {8'h00, diff9[7:0]};
                rsp.flags_out = {zf, 1'b1, hdiff5[4], diff9[8]};
            end
            sm83alu_pkg::CMD_ADC, sm83alu_pkg::CMD_ADD8:
            begin
                zf = (sum9[7:0] == 8'h00);
                rsp.result    = {8'h00, sum9[7:0]};
                rsp.flags_out = {zf, 1'b0, hsum5[4], sum9[8]};
            end
            sm83alu_pkg::CMD_ADD16:
            begin
                rsp.result    = sum17[15:0];
                rsp.flags_out = {req.flags_in[sm83alu_pkg::FLAG_Z], 1'b0, sum13[12], sum17[16]};
            end
            sm83alu_pkg::CMD_ADD_SP:
            begin
                // Flags come from the unsigned low-byte add, not the signed sum.
                rsp.result    = req.operand_a + ext;
                rsp.flags_out = {1'b0, 1'b0, hsum5[4], sum9[8]};
            end
            default:
            begin
                rsp.result    = req.operand_a;
                rsp.flags_out = req.flags_in;
            end
        endcase
    end

endmodule

/* sv/sm83_alu_with_flags_core.sv */
// SM83 style ALU with flags, as a two-register stream stage.
// Input channel s_axis_*: one request per handshake carries the operation code,
// both 16-bit operands and the current Z N H C flags, packed in s_axis_tdata.
// Output channel m_axis_*: one result per request, the 16-bit result and the
// new flags, packed in m_axis_tdata. Results leave in request order.
// A request is accepted at a rising edge with tvalid and tready both high.
// The request is captured in the input register at the accepting edge, the
// ALU logic between the input and result registers is a single pass of short
// adders and selection, and the result is loaded into the result register as
// soon as that register is empty or being drained, and the receiver takes it there.
// Throughput is one request per cycle whenever the receiver keeps tready high.
// If the receiver stalls, the result register holds its data steady and the
// input register still takes one more request, after which s_axis_tready drops
// until the receiver takes the waiting result.
// Reset (rst_n low, asynchronous) empties both registers, so no result is
// shown and a request can be taken straight after reset is released.
module sm83_alu_with_flags_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // From bit 0: cmd[3:0], operand_a[15:0], operand_b[15:0], flags_in[3:0].
    input  logic [sm83alu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // From bit 0: result[15:0], flags_out[3:0], four zero bits.
    output logic [sm83alu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic                  in_vld_reg;
    logic                  in_vld_next;
    sm83alu_pkg::alu_req_t in_req_reg;
    logic                  out_vld_reg;
    logic                  out_vld_next;
    sm83alu_pkg::alu_rsp_t out_rsp_reg;
    sm83alu_pkg::alu_rsp_t alu_rsp;
    logic                  s_hs;
    logic                  advance;

    // The result register can take a new value when it is empty or being
    // drained this cycle; the input register refills under the same rule.
    assign advance       = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = !in_vld_reg || advance;
    assign s_hs          = s_axis_tvalid && s_axis_tready;

    assign in_vld_next  = s_hs || (in_vld_reg && !advance);
    assign out_vld_next = advance ? in_vld_reg : out_vld_reg;

    sm83alu_exec u_exec
    (
        .req (in_req_reg),
        .rsp (alu_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_hs)
        begin
            in_req_reg <= s_axis_tdata;
        end
        if (advance && in_vld_reg)
        begin
            out_rsp_reg <= alu_rsp;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'b0000, out_rsp_reg};

endmodule

/* sv/sm83alu_chk.sv */
module sm83alu_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // A stalled result keeps its data.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A receiver that is taking results never blocks new requests.
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input blocked with output ready");

    // A result is shown when the receiver is ready in the cycle after acceptance.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result missing after two cycles");

    // Padding bits above the flags stay zero.
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:20] == 4'b0000))
        else $error("nonzero padding in result");

endmodule

bind sm83_alu_with_flags_core sm83alu_chk u_chk (.*);
